@@ rtl/pts_pkg.sv @@
// Shared types and codes for the priority task scheduler.
package pts_pkg;

  typedef enum logic [2:0] {
    KIND_CREATE = 3'd0,
    KIND_START  = 3'd1,
    KIND_SWITCH = 3'd2,
    KIND_DELAY  = 3'd3,
    KIND_WAIT   = 3'd4,
    KIND_SIGNAL = 3'd5,
    KIND_WAKE   = 3'd6,
    KIND_BAD    = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_SUSPENDED = 3'd0,
    ST_RUNNING   = 3'd1,
    ST_DELAY     = 3'd2,
    ST_EVENT     = 3'd3,
    ST_READY     = 3'd4
  } task_state_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  localparam int unsigned TickW = 32;
  localparam int unsigned SlotFieldW = 3;

endpackage

@@ rtl/pts_cell.sv @@
// One slot cell: passes the better of its slot and the incoming best to its neighbor.
module pts_cell #(
  parameter int unsigned SLOT_ID = 1,
  parameter int unsigned SW = 3,
  parameter int unsigned PW = 8
) (
  input  logic          clk,
  input  logic          elig,
  input  logic [PW-1:0] prio,
  input  logic [SW-1:0] rank,
  input  logic          scan_en,
  input  logic          best_in_vld,
  input  logic [SW-1:0] best_in,
  input  logic [PW-1:0] best_in_prio,
  input  logic [SW-1:0] best_in_rank,
  output logic          best_vld,
  output logic [SW-1:0] best,
  output logic [PW-1:0] best_prio,
  output logic [SW-1:0] best_rank
);
  logic take;

  // best_in_vld low means idle is current best: tie goes to the real task
  assign take = elig && (!best_in_vld ? (prio >= best_in_prio) :
                ((prio > best_in_prio) || (prio == best_in_prio && rank < best_in_rank)));

  always_ff @(posedge clk) begin
    if (scan_en) begin
      best_vld  <= best_in_vld || take;
      best      <= take ? SW'(SLOT_ID) : best_in;
      best_prio <= take ? prio : best_in_prio;
      best_rank <= take ? rank : best_in_rank;
    end
  end
endmodule

@@ rtl/priority_task_scheduler.sv @@
// Top level of the priority task scheduler.
// Each request gives one response. Create, start, signal, wake and bad
// requests pass straight through the scan state; switch, delay and wait stay
// in it for the priority scan through the row of slot cells, one cell per cycle.
// One request is handled at a time; the response sits in an output register.
module priority_task_scheduler #(
  parameter int unsigned TASK_SLOTS = 8,
  parameter int unsigned PRIORITY_BITS = 8,
  parameter int unsigned EVENT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // kind[2:0], task_slot[5:3], task_priority_in[13:6], delay_ticks[45:14],
  // event_bits[61:46], zero[63:62]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // active_slot[2:0], tick_now[34:3], active_events[50:35], bad_request[51],
  // zero[55:52]
  output logic [55:0] m_tdata
);
  import pts_pkg::*;

  localparam int unsigned SW = $clog2(TASK_SLOTS);
  localparam int unsigned PW = PRIORITY_BITS;
  localparam int unsigned EW = EVENT_BITS;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);

  task_state_t      slot_state [TASK_SLOTS];
  logic [PW-1:0]    slot_priority [TASK_SLOTS];
  logic [TickW-1:0] wake_time [TASK_SLOTS];
  logic [EW-1:0]    wait_mask [TASK_SLOTS];
  logic [EW-1:0]    pending_events [TASK_SLOTS];
  logic [SW-1:0]    creation_rank [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] slot_used;
  logic [SW-1:0]    running_slot;
  logic [TickW-1:0] tick_counter;
  logic [SW-1:0]    newest_slot;

  fsm_t state, state_next;
  logic [CW-1:0] scan_cnt;

  logic [2:0]       req_kind;
  logic [SlotFieldW-1:0] req_slot;
  logic [PW-1:0]    req_prio;
  logic [TickW-1:0] req_dly;
  logic [EW-1:0]    req_bits;
  logic             req_bad;
  logic [SW-1:0]    rs;
  logic             slot_ok;

  logic [SW-1:0]    out_slot;
  logic [TickW-1:0] out_tick;
  logic [EW-1:0]    out_events;
  logic             out_bad;

  logic [TASK_SLOTS-1:0] elig;
  logic [TASK_SLOTS-1:0]         c_vld;
  logic [TASK_SLOTS-1:0][SW-1:0] c_best, c_rank;
  logic [TASK_SLOTS-1:0][PW-1:0] c_prio;
  logic [CW-1:0] used_cnt;

  assign s_tready = (state == FSM_IDLE) && !m_tvalid;
  assign rs = SW'(req_slot);
  assign slot_ok = (32'(req_slot) < TASK_SLOTS) && (req_slot != '0);

  always_comb begin
    used_cnt = '0;
    for (int i = 0; i < TASK_SLOTS; i++) used_cnt = used_cnt + CW'(slot_used[i]);
  end

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++)
      elig[i] = slot_used[i] && ((slot_state[i] == ST_READY) ||
                (slot_state[i] == ST_DELAY && wake_time[i] <= tick_counter));
  end

  // cell 0 seeds the chain with idle (priority of slot 0)
  assign c_vld[0]  = 1'b0;
  assign c_best[0] = '0;
  assign c_prio[0] = slot_priority[0];
  assign c_rank[0] = '0;

  for (genvar g = 1; g < TASK_SLOTS; g++) begin : g_cell
    pts_cell #(.SLOT_ID(g), .SW(SW), .PW(PW)) u_cell (
      .clk, .elig(elig[g]), .prio(slot_priority[g]), .rank(creation_rank[g]),
      .scan_en(state == FSM_SCAN && scan_cnt == CW'(g)),
      .best_in_vld(c_vld[g-1]), .best_in(c_best[g-1]),
      .best_in_prio(c_prio[g-1]), .best_in_rank(c_rank[g-1]),
      .best_vld(c_vld[g]), .best(c_best[g]),
      .best_prio(c_prio[g]), .best_rank(c_rank[g])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: if (s_tvalid && s_tready) state_next = FSM_SCAN;
      FSM_SCAN: begin
        if (req_kind != KIND_SWITCH && req_kind != KIND_DELAY && req_kind != KIND_WAIT)
          state_next = FSM_DONE;
        else if (scan_cnt == CW'(TASK_SLOTS - 1)) state_next = FSM_DONE;
      end
      FSM_DONE: state_next = FSM_IDLE;
      default:  state_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= FSM_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_kind <= s_tdata[2:0];
      req_slot <= s_tdata[5:3];
      req_prio <= PW'(s_tdata[13:6]);
      req_dly  <= s_tdata[45:14];
      req_bits <= EW'(s_tdata[61:46]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_state[i] <= ST_SUSPENDED;
        slot_priority[i] <= '0;
        wake_time[i] <= '0;
        wait_mask[i] <= '0;
        pending_events[i] <= '0;
        creation_rank[i] <= '0;
      end
      slot_state[0] <= ST_READY;
      slot_used <= TASK_SLOTS'(1);
      running_slot <= '0;
      tick_counter <= '0;
      newest_slot <= '0;
      scan_cnt <= '0;
      req_bad <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (s_tvalid && s_tready) scan_cnt <= '0;
      if (state == FSM_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
        if (scan_cnt == '0) begin
          req_bad <= 1'b0;
          unique case (req_kind)
            KIND_CREATE: begin
              if (!slot_ok) req_bad <= 1'b1;
              else begin
                if (!slot_used[rs]) begin
                  creation_rank[rs] <= SW'(used_cnt);
                  slot_used[rs] <= 1'b1;
                end
                slot_priority[rs] <= req_prio;
                slot_state[rs] <= ST_READY;
                wake_time[rs] <= '0;
                wait_mask[rs] <= '0;
                pending_events[rs] <= '0;
                newest_slot <= rs;
              end
            end
            KIND_START: begin
              if (slot_state[running_slot] == ST_RUNNING)
                slot_state[running_slot] <= ST_READY;
              slot_state[newest_slot] <= ST_RUNNING;
              running_slot <= newest_slot;
            end
            KIND_SWITCH: begin
              if (slot_state[running_slot] == ST_RUNNING)
                slot_state[running_slot] <= ST_READY;
              tick_counter <= tick_counter + 1'b1;
            end
            KIND_DELAY: begin
              wake_time[running_slot] <= tick_counter + req_dly;
              slot_state[running_slot] <= ST_DELAY;
              tick_counter <= tick_counter + 1'b1;
            end
            KIND_WAIT: begin
              wait_mask[running_slot] <= req_bits;
              pending_events[running_slot] <= pending_events[running_slot] & ~req_bits;
              slot_state[running_slot] <= ST_EVENT;
              tick_counter <= tick_counter + 1'b1;
            end
            KIND_SIGNAL: begin
              if (!slot_ok || !slot_used[rs]) req_bad <= 1'b1;
              else begin
                pending_events[rs] <= pending_events[rs] | req_bits;
                if ((req_bits & wait_mask[rs]) != '0) slot_state[rs] <= ST_READY;
              end
            end
            KIND_WAKE: begin
              if (32'(req_slot) >= TASK_SLOTS || !slot_used[rs]) req_bad <= 1'b1;
              else wake_time[rs] <= '0;
            end
            default: req_bad <= 1'b1;
          endcase
        end
      end
      if (state == FSM_DONE) begin
        if (req_kind == KIND_SWITCH || req_kind == KIND_DELAY || req_kind == KIND_WAIT) begin
          running_slot <= c_best[TASK_SLOTS-1];
          slot_state[c_best[TASK_SLOTS-1]] <= ST_RUNNING;
        end
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == FSM_DONE) begin
      out_bad  <= req_bad;
      out_tick <= tick_counter;
      if (req_kind == KIND_SWITCH || req_kind == KIND_DELAY || req_kind == KIND_WAIT) begin
        out_slot   <= c_best[TASK_SLOTS-1];
        out_events <= pending_events[c_best[TASK_SLOTS-1]];
      end else begin
        out_slot   <= running_slot;
        out_events <= pending_events[running_slot];
      end
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[2:0]   = 3'(out_slot);
    m_tdata[34:3]  = out_tick;
    m_tdata[50:35] = 16'(out_events);
    m_tdata[51]    = out_bad;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != FSM_IDLE) |-> !s_tready) else $error("accept while busy");
  a_done_gives_resp: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_DONE) |=> m_tvalid) else $error("missing response");
  a_idle_used: assert property (@(posedge clk) disable iff (rst)
    slot_used[0]) else $error("idle slot lost");
  a_tick_steps: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_IDLE) |=> (tick_counter == $past(tick_counter)))
    else $error("tick moved while idle");
`endif
endmodule

@@ verif/priority_task_scheduler_chk.sv @@
// Checker: watches both channels, predicts scheduler responses and compares them.
`timescale 1ns / 100ps
module priority_task_scheduler_chk
  import pts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  output int          fail_count,
  output int          pending_count
);

  localparam int NSLOT = 8;

  // last member sits in the lowest bits, matching the response packing
  typedef struct packed {
    logic        bad;
    logic [15:0] events;
    logic [31:0] tick;
    logic [2:0]  slot;
  } resp_t;

  task_state_t st_q[NSLOT];
  logic [7:0]  prio_q[NSLOT];
  logic [31:0] wake_q[NSLOT];
  logic [15:0] mask_q[NSLOT];
  logic [15:0] evt_q[NSLOT];
  logic [2:0]  rank_q[NSLOT];
  logic        used_q[NSLOT];
  logic [2:0]  run_q;
  logic [31:0] tick_q;
  logic [2:0]  newest_q;
  resp_t       resp_fifo[$];

  function automatic bit is_eligible(int s);
    if (!used_q[s]) return 0;
    if (st_q[s] == ST_READY) return 1;
    return st_q[s] == ST_DELAY && wake_q[s] <= tick_q;
  endfunction

  task automatic reschedule();
    int best;
    best = 0;
    if (st_q[run_q] == ST_RUNNING) st_q[run_q] = ST_READY;
    tick_q = tick_q + 1;
    for (int s = 1; s < NSLOT; s++) begin
      if (!is_eligible(s)) continue;
      if (best == 0) begin
        if (prio_q[s] >= prio_q[0]) best = s;
      end else if (prio_q[s] > prio_q[best] ||
                   (prio_q[s] == prio_q[best] && rank_q[s] < rank_q[best])) begin
        best = s;
      end
    end
    run_q = best[2:0];
    st_q[best] = ST_RUNNING;
  endtask

  task automatic apply_request(logic [63:0] d);
    kind_t       k;
    logic [2:0]  sl;
    logic [7:0]  pr;
    logic [31:0] dl;
    logic [15:0] bits;
    logic        bad;
    logic [2:0]  r;
    int          n;
    resp_t       e;
    k = kind_t'(d[2:0]);
    sl = d[5:3];
    pr = d[13:6];
    dl = d[45:14];
    bits = d[61:46];
    bad = 0;
    r = run_q;
    case (k)
      KIND_CREATE: begin
        if (sl == 0) bad = 1;
        else begin
          if (!used_q[sl]) begin
            n = 0;
            for (int s = 0; s < NSLOT; s++) if (used_q[s]) n++;
            rank_q[sl] = n[2:0];
            used_q[sl] = 1;
          end
          prio_q[sl] = pr;
          st_q[sl] = ST_READY;
          wake_q[sl] = '0;
          mask_q[sl] = '0;
          evt_q[sl] = '0;
          newest_q = sl;
        end
      end
      KIND_START: begin
        if (st_q[r] == ST_RUNNING) st_q[r] = ST_READY;
        run_q = newest_q;
        st_q[newest_q] = ST_RUNNING;
      end
      KIND_SWITCH: reschedule();
      KIND_DELAY: begin
        wake_q[r] = tick_q + dl;
        st_q[r] = ST_DELAY;
        reschedule();
      end
      KIND_WAIT: begin
        mask_q[r] = bits;
        evt_q[r] = evt_q[r] & ~bits;
        st_q[r] = ST_EVENT;
        reschedule();
      end
      KIND_SIGNAL: begin
        if (sl == 0 || !used_q[sl]) bad = 1;
        else begin
          evt_q[sl] = evt_q[sl] | bits;
          if ((bits & mask_q[sl]) != 0) st_q[sl] = ST_READY;
        end
      end
      KIND_WAKE: begin
        if (!used_q[sl]) bad = 1;
        else wake_q[sl] = '0;
      end
      default: bad = 1;
    endcase
    e.slot = run_q;
    e.tick = tick_q;
    e.events = evt_q[run_q];
    e.bad = bad;
    resp_fifo.push_back(e);
  endtask

  always @(posedge clk) begin
    resp_t e;
    resp_t a;
    if (rst) begin
      for (int s = 0; s < NSLOT; s++) begin
        st_q[s] = ST_SUSPENDED;
        prio_q[s] = '0;
        wake_q[s] = '0;
        mask_q[s] = '0;
        evt_q[s] = '0;
        rank_q[s] = '0;
        used_q[s] = 0;
      end
      st_q[0] = ST_READY;
      used_q[0] = 1;
      run_q = '0;
      tick_q = '0;
      newest_q = '0;
      resp_fifo.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        a = m_tdata[51:0];
        if (resp_fifo.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected response %h", m_tdata);
        end else begin
          e = resp_fifo.pop_front();
          if (a !== e) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: exp slot %0d tick %0d evt %h bad %0d, ",
                        "got slot %0d tick %0d evt %h bad %0d"},
                       e.slot, e.tick, e.events, e.bad, a.slot, a.tick, a.events, a.bad);
          end
        end
      end
      if (s_tvalid && s_tready) apply_request(s_tdata);
    end
    pending_count = resp_fifo.size();
  end

endmodule

@@ verif/priority_task_scheduler_tb.sv @@
// Testbench top: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 100ps
module priority_task_scheduler_tb;
  import pts_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct = 15;
  int          recv_idle_pct = 62;
  logic        hold_start = 0;
  logic        hold_done = 0;
  int          hold_off = 0;
  int          cycle_count = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  priority_task_scheduler i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  priority_task_scheduler_chk i_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_start && !hold_done) begin
      hold_done <= 1;
      hold_off <= 300;
      m_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] pack_req(kind_t k, logic [2:0] sl, logic [7:0] pr,
                                           logic [31:0] dl, logic [15:0] ev);
    return {2'b00, ev, dl, pr, sl, k};
  endfunction

  task automatic send_req(logic [63:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_delay();
    case ($urandom_range(3))
      0: return 32'hFFFF_FFFF;
      1: return $urandom();
      default: return $urandom_range(6);
    endcase
  endfunction

  task automatic send_random();
    int    p;
    kind_t k;
    p = $urandom_range(99);
    if (p < 15) k = KIND_CREATE;
    else if (p < 20) k = KIND_START;
    else if (p < 50) k = KIND_SWITCH;
    else if (p < 62) k = KIND_DELAY;
    else if (p < 72) k = KIND_WAIT;
    else if (p < 87) k = KIND_SIGNAL;
    else if (p < 97) k = KIND_WAKE;
    else k = KIND_BAD;
    send_req(pack_req(k, 3'($urandom_range(7)),
                      ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(3)),
                      rand_delay(),
                      ($urandom_range(1)) ? 16'($urandom()) : 16'(1 << $urandom_range(15))));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_req(pack_req(KIND_SWITCH, 0, 0, 0, 0));
    send_req(pack_req(KIND_START, 0, 0, 0, 0));
    send_req(pack_req(KIND_CREATE, 0, 8'hFF, 0, 0));
    send_req(pack_req(KIND_SIGNAL, 0, 0, 0, 16'hFFFF));
    send_req(pack_req(KIND_SIGNAL, 3, 0, 0, 16'hFFFF));
    send_req(pack_req(KIND_WAKE, 5, 0, 0, 0));
    send_req(pack_req(KIND_BAD, 7, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_req(pack_req(KIND_CREATE, 7, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_req(pack_req(KIND_CREATE, 2, 8'hFF, 0, 0));
    send_req(pack_req(KIND_CREATE, 1, 8'h00, 0, 0));
    send_req(pack_req(KIND_START, 0, 0, 0, 0));
    send_req(pack_req(KIND_SWITCH, 0, 0, 0, 0));
    send_req(pack_req(KIND_WAIT, 0, 0, 0, 16'hA5A5));
    send_req(pack_req(KIND_SIGNAL, 7, 0, 0, 16'h0101));
    send_req(pack_req(KIND_SIGNAL, 7, 0, 0, 16'h5A5A));
    send_req(pack_req(KIND_DELAY, 0, 0, 32'hFFFF_FFFF, 0));
    send_req(pack_req(KIND_DELAY, 0, 0, 32'd2, 0));
    send_req(pack_req(KIND_SWITCH, 0, 0, 0, 0));
    send_req(pack_req(KIND_WAKE, 2, 0, 0, 0));
    send_req(pack_req(KIND_SWITCH, 0, 0, 0, 0));
    send_req(pack_req(KIND_WAKE, 0, 0, 0, 0));
    send_req(pack_req(KIND_CREATE, 2, 8'h01, 0, 0));
    send_req(pack_req(KIND_WAIT, 0, 0, 0, 16'h0000));
    for (int i = 0; i < 450; i++) send_random();
    send_idle_pct = 62;
    recv_idle_pct = 15;
    hold_start <= 1;
    for (int i = 0; i < 450; i++) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 430; i++) send_random();
    s_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pts_pkg.sv
rtl/pts_cell.sv
rtl/priority_task_scheduler.sv
verif/priority_task_scheduler_chk.sv
verif/priority_task_scheduler_tb.sv
